// ----- rtl/iec_pkg.sv -----
// Shared types, character codes and operation codes for the calculator.
`default_nettype none

package iec_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RESULT_W       = 32;
    localparam int SYM_W          = 8;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
    localparam logic [SYM_W-1:0] CH_TIMES = 8'd42;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'd47;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic                       divide_by_zero;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic accum;
        logic apply_quick;
        logic start_unit;
        logic apply_unit;
        logic set_pending;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_op;
        logic is_digit;
        logic last;
        logic pend_long;
        logic unit_done;
        logic out_free;
    } status_t;

    function automatic op_t op_of(input logic [SYM_W-1:0] c);
        op_t r;
        case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_TIMES: r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/immediate_execution_calculator.sv -----
// Top level of the immediate-execution four-function calculator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid / in_ready  | in_item  : symbol[7:0], last
//   out     | output    | out_valid / out_ready| out_item : result_value[31:0], divide_by_zero
//
// Each accepted item is captured, then handled in S_STEP: a digit accumulates, an ignored code
// does nothing, and an operator after add, subtract or nothing applies at once. An operator
// that applies a pending multiply or divide starts the shared one-bit-per-cycle unit and waits
// in S_WAIT_OP for its result; a divide by 0 skips the iteration. A last item adds the final
// apply (S_FINAL, S_WAIT_FIN) and S_EMIT, which loads the output register. Reset clears control,
// operand and flag state; a stalled result holds while later items go in, stalling only the next emit.
`default_nettype none

module immediate_execution_calculator #(
    parameter int VALUE_BITS = iec_pkg::VALUE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire iec_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output iec_pkg::out_item_t      out_item
);
    import iec_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: decides per symbol whether to accumulate, apply or emit.
    iec_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Operands, pending op, sticky error, multiply/divide unit, output register.
    iec_datapath #(
        .VALUE_BITS(VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

`ifndef SYNTHESIS
    // Never overwrite a result that is still waiting to be taken.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result emitted over a stalled item");

    // Ready is never held across an accepted item: the block goes busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready held across an accepted item");

    // At most one datapath action per cycle.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accum, cmd.apply_quick, cmd.start_unit, cmd.apply_unit, cmd.emit}))
        else $error("conflicting datapath commands");

    // A new result appears only after an emit command.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output valid without emit");
`endif

endmodule

`default_nettype wire

// ----- rtl/iec_muldiv.sv -----
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none

module iec_muldiv #(
    parameter int VALUE_BITS = iec_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  is_div,
    input  wire logic [VALUE_BITS-1:0] opnd_a,
    input  wire logic [VALUE_BITS-1:0] opnd_b,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      result,
    output logic                       div_zero
);
    import iec_pkg::*;

    localparam int N     = VALUE_BITS;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg;
    logic             neg_reg;
    logic             dz_reg;
    logic [N-1:0]     acc_reg, acc_next;
    logic [N-1:0]     opa_reg, opa_next;
    logic [N-1:0]     opb_reg, opb_next;
    logic [N-1:0]     res_reg;

    logic [N-1:0] mag_a, mag_b;
    logic [N-1:0] shifted;
    logic [N:0]   trial;
    logic [N-1:0] quo;
    logic [N-1:0] fin_val;
    logic         b_zero;
    logic         final_step;

    assign mag_a      = opnd_a[N-1] ? (~opnd_a + 1'b1) : opnd_a;
    assign mag_b      = opnd_b[N-1] ? (~opnd_b + 1'b1) : opnd_b;
    assign b_zero     = (opnd_b == '0);
    assign final_step = busy_reg && (cnt_reg == CNT_LAST);

    // Remainder never exceeds half range, so the top bit drops on the shift.
    assign shifted = {acc_reg[N-2:0], opb_reg[N-1]};
    assign trial   = {1'b0, shifted} - {1'b0, opa_reg};
    assign quo     = {opb_reg[N-2:0], ~trial[N]};

    always_comb
    begin
        if (div_reg)
        begin
            acc_next = trial[N] ? shifted : trial[N-1:0];
            opa_next = opa_reg;
            opb_next = quo;
            fin_val  = neg_reg ? (~quo + 1'b1) : quo;
        end
        else
        begin
            acc_next = acc_reg + (opb_reg[0] ? opa_reg : '0);
            opa_next = {opa_reg[N-2:0], 1'b0};
            opb_next = {1'b0, opb_reg[N-1:1]};
            fin_val  = acc_next;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (is_div && b_zero)
            begin
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (final_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= is_div;
            neg_reg <= opnd_a[N-1] ^ opnd_b[N-1];
            dz_reg  <= is_div && b_zero;
            acc_reg <= '0;
            res_reg <= '0;
            if (is_div)
            begin
                opa_reg <= mag_b;
                opb_reg <= mag_a;
            end
            else
            begin
                opa_reg <= opnd_a;
                opb_reg <= opnd_b;
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            opa_reg <= opa_next;
            opb_reg <= opb_next;
            if (final_step)
            begin
                res_reg <= fin_val;
            end
        end
    end

    assign done     = done_reg;
    assign result   = res_reg;
    assign div_zero = dz_reg;

endmodule

`default_nettype wire

// ----- rtl/iec_datapath.sv -----
// Operand, pending-operation and result registers with the arithmetic unit.
`default_nettype none

module iec_datapath #(
    parameter int VALUE_BITS = iec_pkg::VALUE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire iec_pkg::in_item_t  in_item,
    input  wire iec_pkg::cmd_t      cmd,
    output iec_pkg::status_t        status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output iec_pkg::out_item_t      out_item
);
    import iec_pkg::*;

    localparam int N = VALUE_BITS;

    logic [SYM_W-1:0] sym_reg;
    logic             last_reg;
    logic [N-1:0]     left_reg, left_next;
    logic [N-1:0]     right_reg, right_next;
    op_t              op_reg, op_next;
    logic             err_reg, err_next;
    logic             out_valid_reg;
    out_item_t        out_reg;

    op_t          sym_op;
    logic         sym_digit;
    logic [N-1:0] digit_val;
    logic [N-1:0] accum_src;
    logic [N-1:0] accum_val;
    logic [N-1:0] quick_val;
    logic         unit_done;
    logic [N-1:0] unit_result;
    logic         unit_dz;
    logic         out_free;

    assign sym_op    = op_of(sym_reg);
    assign sym_digit = (sym_reg inside {[CH_ZERO:CH_NINE]});
    assign digit_val = N'(sym_reg - CH_ZERO);
    assign accum_src = (op_reg == OP_NONE) ? left_reg : right_reg;
    // times ten as two shifts and an add
    assign accum_val = {accum_src[N-4:0], 3'b000} + {accum_src[N-2:0], 1'b0} + digit_val;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  quick_val = left_reg + right_reg;
            OP_SUB:  quick_val = left_reg - right_reg;
            default: quick_val = left_reg;
        endcase
    end

    iec_muldiv #(
        .VALUE_BITS(VALUE_BITS)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start_unit),
        .is_div  (op_reg == OP_DIV),
        .opnd_a  (left_reg),
        .opnd_b  (right_reg),
        .done    (unit_done),
        .result  (unit_result),
        .div_zero(unit_dz)
    );

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        op_next    = op_reg;
        err_next   = err_reg;
        if (cmd.emit)
        begin
            left_next  = '0;
            right_next = '0;
            op_next    = OP_NONE;
            err_next   = 1'b0;
        end
        else
        begin
            if (cmd.apply_unit)
            begin
                left_next  = unit_result;
                right_next = '0;
                err_next   = err_reg | unit_dz;
            end
            else if (cmd.apply_quick)
            begin
                left_next  = quick_val;
                right_next = '0;
            end
            else if (cmd.accum)
            begin
                if (op_reg == OP_NONE)
                begin
                    left_next = accum_val;
                end
                else
                begin
                    right_next = accum_val;
                end
            end
            if (cmd.set_pending)
            begin
                op_next = sym_op;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            op_reg        <= OP_NONE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            op_reg    <= op_next;
            err_reg   <= err_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sym_reg  <= in_item.symbol;
            last_reg <= in_item.last;
        end
        if (cmd.emit)
        begin
            out_reg.result_value   <= $signed(RESULT_W'(left_reg));
            out_reg.divide_by_zero <= err_reg;
        end
    end

    assign status.is_op     = (sym_op != OP_NONE);
    assign status.is_digit  = sym_digit;
    assign status.last      = last_reg;
    assign status.pend_long = (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign status.unit_done = unit_done;
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/iec_ctrl.sv -----
// Sequencer for symbol handling, pending-operation apply and result hand-off.
`default_nettype none

module iec_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire iec_pkg::status_t status,
    output iec_pkg::cmd_t         cmd
);
    import iec_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_WAIT_OP,
        S_FINAL,
        S_WAIT_FIN,
        S_EMIT
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    ctrl_state_t after_sym;

    assign after_sym = status.last ? S_FINAL : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (status.is_op)
                begin
                    if (status.pend_long)
                    begin
                        cmd.start_unit = 1'b1;
                        state_next     = S_WAIT_OP;
                    end
                    else
                    begin
                        cmd.apply_quick = 1'b1;
                        cmd.set_pending = 1'b1;
                        state_next      = after_sym;
                    end
                end
                else
                begin
                    cmd.accum  = status.is_digit;
                    state_next = after_sym;
                end
            end
            S_WAIT_OP:
            begin
                if (status.unit_done)
                begin
                    cmd.apply_unit  = 1'b1;
                    cmd.set_pending = 1'b1;
                    state_next      = after_sym;
                end
            end
            S_FINAL:
            begin
                if (status.pend_long)
                begin
                    cmd.start_unit = 1'b1;
                    state_next     = S_WAIT_FIN;
                end
                else
                begin
                    cmd.apply_quick = 1'b1;
                    state_next      = S_EMIT;
                end
            end
            S_WAIT_FIN:
            begin
                if (status.unit_done)
                begin
                    cmd.apply_unit = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ----- tb/immediate_execution_calculator_tb.sv -----
// Self-checking testbench for the immediate-execution calculator: directed and random expressions.
`default_nettype none

module immediate_execution_calculator_tb;

    import iec_pkg::*;

    localparam int VB         = VALUE_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int HOLD_LONG  = 500;    // receiver hold-off that backs the block up
    localparam int ITEM_GOAL  = 600;    // digits, operators and last symbols to send

    // Expected-result tracker: mirrors the calculator state and queues each
    // expression value it predicts when the last symbol is accepted.
    class calc_scoreboard;
        logic [VB-1:0] lhs;
        logic [VB-1:0] rhs;
        op_t           pend;
        bit            dz_seen;
        out_item_t     value_q[$];
        int            mismatches;
        int            checked;
        int            dz_results;
        int            symbols_seen;

        function new();
            clear_expr();
            mismatches   = 0;
            checked      = 0;
            dz_results   = 0;
            symbols_seen = 0;
        endfunction

        function void clear_expr();
            lhs     = '0;
            rhs     = '0;
            pend    = OP_NONE;
            dz_seen = 1'b0;
        endfunction

        // Truncate toward zero; the most negative value over -1 wraps to itself.
        function logic [VB-1:0] trunc_div(logic [VB-1:0] a, logic [VB-1:0] b);
            logic [VB-1:0] ma;
            logic [VB-1:0] mb;
            logic [VB-1:0] q;
            if (b == '0)
            begin
                dz_seen = 1'b1;
                return '0;
            end
            ma = a[VB-1] ? -a : a;
            mb = b[VB-1] ? -b : b;
            q  = ma / mb;
            if (a[VB-1] ^ b[VB-1])
                q = -q;
            return q;
        endfunction

        function void fold_pending();
            case (pend)
                OP_ADD:  lhs = lhs + rhs;
                OP_SUB:  lhs = lhs - rhs;
                OP_MUL:  lhs = lhs * rhs;
                OP_DIV:  lhs = trunc_div(lhs, rhs);
                default: ;
            endcase
            rhs = '0;
        endfunction

        function void note_input(in_item_t it);
            op_t       op;
            out_item_t res;
            symbols_seen++;
            if (it.symbol == CH_PLUS)
                op = OP_ADD;
            else if (it.symbol == CH_MINUS)
                op = OP_SUB;
            else if (it.symbol == CH_TIMES)
                op = OP_MUL;
            else if (it.symbol == CH_SLASH)
                op = OP_DIV;
            else
                op = OP_NONE;

            if (op != OP_NONE)
            begin
                fold_pending();
                pend = op;
            end
            else if (it.symbol >= CH_ZERO && it.symbol <= CH_NINE)
            begin
                if (pend == OP_NONE)
                    lhs = lhs * 10 + VB'(it.symbol - CH_ZERO);
                else
                    rhs = rhs * 10 + VB'(it.symbol - CH_ZERO);
            end

            if (it.last)
            begin
                fold_pending();
                res.result_value   = lhs[RESULT_W-1:0];
                res.divide_by_zero = dz_seen;
                value_q = {value_q, res};
                clear_expr();
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (value_q.size() == 0)
            begin
                $error("unexpected result: result_value %0d divide_by_zero %0b",
                       got.result_value, got.divide_by_zero);
                mismatches++;
                return;
            end
            want = value_q.pop_front();
            checked++;
            if (got.divide_by_zero)
                dz_results++;
            if (got.result_value !== want.result_value)
            begin
                $error("result_value: expected %0d actual %0d",
                       want.result_value, got.result_value);
                mismatches++;
            end
            if (got.divide_by_zero !== want.divide_by_zero)
            begin
                $error("divide_by_zero: expected %0b actual %0b",
                       want.divide_by_zero, got.divide_by_zero);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return value_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    calc_scoreboard sb;

    int       idle_cycles;
    int       useful_sent;
    int       expr_count;
    bit       steady;       // burst stretch: neither side idles
    bit       hold_req;     // ask the receiver for one long hold-off
    in_item_t expr_q[$];

    immediate_execution_calculator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Sample both channels at the rising edge; feed the tracker and run the
    // watchdog on cycles where no item moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Mostly zero (always zero while steady), sometimes a short gap, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic in_item_t mk(logic [7:0] sym, logic lst);
        in_item_t it;
        it.symbol = sym;
        it.last   = lst;
        return it;
    endfunction

    function automatic bit is_meaningful(in_item_t it);
        return it.last || (it.symbol >= CH_ZERO && it.symbol <= CH_NINE) ||
               it.symbol == CH_PLUS || it.symbol == CH_MINUS ||
               it.symbol == CH_TIMES || it.symbol == CH_SLASH;
    endfunction

    // Enter and leave at a falling edge. Hold valid and payload until accepted.
    task automatic send_item(in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        if (is_meaningful(it))
            useful_sent++;
        if (it.last)
            expr_count++;
        @(negedge clk);
    endtask

    // Send a literal string; mark its final character last when close is set.
    task automatic send_text(string s, bit close);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(mk(s[i], close && (i == s.len() - 1)));
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] op_char(int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_TIMES;
            default: return CH_SLASH;
        endcase
    endfunction

    task automatic push_sym(logic [7:0] sym);
        expr_q = {expr_q, mk(sym, 1'b0)};
        // Sprinkle ignored noise between symbols now and then.
        if ($urandom_range(0, 99) < 5)
            expr_q = {expr_q, mk(8'($urandom_range(0, 255)), 1'b0)};
    endtask

    task automatic push_operand(bit allow_zero);
        int r;
        int n;
        int i;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 12)
        begin
            push_sym(CH_ZERO);
            return;
        end
        if (r < 70)
            n = $urandom_range(1, 2);
        else if (r < 90)
            n = $urandom_range(3, 5);
        else
            n = $urandom_range(9, 12);      // 9 to 12 digits, so the longer ones can wrap
        for (i = 0; i < n; i++)
            push_sym(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Build one random expression in expr_q and send it.
    task automatic random_expression();
        int    shape;
        int    nops;
        int    i;
        string corner[5];
        shape = $urandom_range(0, 99);
        corner[0] = "2147483648/4294967295";
        corner[1] = "2147483647+1";
        corner[2] = "0-2147483648/2";
        corner[3] = "4294967295*4294967295";
        corner[4] = "7/0+3";
        expr_q.delete();

        if (shape < 4)
        begin
            send_text(corner[$urandom_range(0, 4)], 1'b1);
            return;
        end

        if (shape < 8)
        begin
            // Single-symbol expression: a random code marked last.
            expr_q = {expr_q, mk(8'($urandom_range(0, 255)), 1'b1)};
        end
        else
        begin
            if (shape >= 90 && shape < 94)
                push_sym(op_char($urandom_range(0, 3)));    // leading operator
            push_operand(1'b0);
            nops = $urandom_range(0, 4);
            for (i = 0; i < nops; i++)
            begin
                push_sym(op_char($urandom_range(0, 3)));
                if (shape >= 94 && $urandom_range(0, 3) == 0)
                    push_sym(op_char($urandom_range(0, 3)));    // doubled operator
                push_operand(1'b1);
            end
            if (shape >= 80 && shape < 86)
                push_sym(op_char($urandom_range(0, 3)));    // operator marked last
            else if (shape >= 86 && shape < 90)
                expr_q = {expr_q, mk(8'($urandom_range(0, 255)), 1'b0)};
            expr_q[expr_q.size() - 1].last = 1'b1;
        end

        for (i = 0; i < expr_q.size(); i++)
            send_item(expr_q[i]);
    endtask

    // Receiver: stall at random, or hold off for one long stretch on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_LONG) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Sender and run control.
    initial
    begin
        bit held;
        bit paused;
        sb          = new();
        idle_cycles = 0;
        useful_sent = 0;
        expr_count  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        held        = 1'b0;
        paused      = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty expression on the top code, operator as last symbol
        // for divide, multiply and add (divide by zero among them), no precedence with an
        // ignored zero code in the middle, and truncation of a negative quotient.
        send_item(mk(8'hFF, 1'b1));
        send_text("5/", 1'b1);
        send_text("5*", 1'b1);
        send_text("5+", 1'b1);
        send_text("8-3", 1'b0);
        send_item(mk(8'h00, 1'b0));
        send_text("*2", 1'b1);
        send_text("0-7/2", 1'b1);
        drain_results();

        // Random: mostly well-formed expressions, some broken ones and noise.
        while (useful_sent < ITEM_GOAL)
        begin
            steady = ($urandom_range(0, 99) < 15);
            if (!held && useful_sent >= 200)
            begin
                held     = 1'b1;
                hold_req = 1'b1;        // keep sending while the receiver sits
            end
            if (!paused && useful_sent >= 400)
            begin
                paused = 1'b1;
                drain_results();
            end
            random_expression();
        end
        in_valid <= 1'b0;

        // Wait out the results, then a tail longer than the worst item.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (2 * VB + 20) @(posedge clk);

        $display("run covered %0d symbols (%0d digits, operators or last) in %0d expressions",
                 sb.symbols_seen, useful_sent, expr_count);
        $display("checked %0d results, %0d flagged divide by zero, %0d mismatches",
                 sb.checked, sb.dz_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
